FILE: design/mcbp_pkg.sv
// mcbp_pkg: shared codes, widths and defaults for the multi-channel byte pipe
// used by multi_channel_byte_pipe and mcbp_byte_ram; depends on nothing

package mcbp_pkg;

    // default geometry
    localparam int DEF_CHANNELS      = 64;
    localparam int DEF_CHANNEL_DEPTH = 256;

    // fixed field widths
    localparam int HANDLE_W = 7;
    localparam int OWNER_W  = 16;
    localparam int PID_W    = 15;
    localparam int BYTE_W   = 8;

    // handle of channel zero and the owner id meaning none
    localparam logic [HANDLE_W-1:0] HANDLE_BASE = 7'd3;
    localparam logic [OWNER_W-1:0]  NO_OWNER    = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_OPEN  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BAD_HANDLE = 3'd1,
        STATUS_NO_FREE    = 3'd2,
        STATUS_NO_OWNER   = 3'd3,
        STATUS_EMPTY      = 3'd4,
        STATUS_FULL       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

FILE: design/mcbp_byte_ram.sv
// mcbp_byte_ram: single-port byte store holding every channel's ring buffer
// depends on mcbp_pkg for the byte width

module mcbp_byte_ram #(
    parameter int ADDR_W = 14
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [mcbp_pkg::BYTE_W-1:0] wr_data,
    output logic [mcbp_pkg::BYTE_W-1:0] rd_data
);
    import mcbp_pkg::*;

    logic [BYTE_W-1:0] mem [2**ADDR_W];
    logic [BYTE_W-1:0] rd_data_reg;

    // one access per cycle, registered read data holds until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/multi_channel_byte_pipe.sv
// multi_channel_byte_pipe: table of byte fifo channels with open, close, read, write
// depends on mcbp_pkg and mcbp_byte_ram
// one item at a time: the next is taken only after the channel table read, the read-modify-write
// and the byte store read of the last one, and once its result is loaded into the output register
// s_ready is high while idle, also while a result waits in the output register
// reset (aresetn, synchronous, active low) clears control, in-use and table valid bits

module multi_channel_byte_pipe #(
    parameter int CHANNELS      = mcbp_pkg::DEF_CHANNELS,
    parameter int CHANNEL_DEPTH = mcbp_pkg::DEF_CHANNEL_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [mcbp_pkg::HANDLE_W-1:0] s_handle,
    input  logic [mcbp_pkg::PID_W-1:0]    s_owner_id,
    input  logic                          s_open_as_writer,
    input  logic [mcbp_pkg::BYTE_W-1:0]   s_data_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [mcbp_pkg::BYTE_W-1:0]   m_data_out,
    output logic [mcbp_pkg::HANDLE_W-1:0] m_new_handle,
    output logic                          m_suspend_valid,
    output logic [mcbp_pkg::OWNER_W-1:0]  m_suspend_id,
    output logic                          m_wake_valid,
    output logic [mcbp_pkg::OWNER_W-1:0]  m_wake_id
);
    import mcbp_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W = $clog2(CHANNEL_DEPTH);
    localparam int OCC_W = $clog2(CHANNEL_DEPTH + 1);
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int RAM_W = CH_W + PTR_W;

    typedef struct packed {
        logic [PTR_W-1:0]   rptr;
        logic [PTR_W-1:0]   wptr;
        logic [OCC_W-1:0]   occ;
        logic               rblk;
        logic               wblk;
        logic [OWNER_W-1:0] rown;
        logic [OWNER_W-1:0] wown;
    } meta_t;

    localparam meta_t META_INIT = '{
        rptr: '0, wptr: '0, occ: '0, rblk: 1'b0, wblk: 1'b0,
        rown: NO_OWNER, wown: NO_OWNER
    };

    function automatic logic handle_bad(input logic [HANDLE_W-1:0] h);
        return (h < HANDLE_BASE) || (h > HANDLE_W'(CHANNELS + 2));
    endfunction

    function automatic logic [CH_W-1:0] handle_ch(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_W-1:0] diff;
        diff = h - HANDLE_BASE;
        return handle_bad(h) ? '0 : CH_W'(diff);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CHANNEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // state and control
    state_t              state_reg, state_next;
    logic [CHANNELS-1:0] in_use_reg;
    logic [CHANNELS-1:0] meta_vld_reg;
    logic [CNT_W-1:0]    open_count_reg;

    // accepted item
    action_t             act_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [PID_W-1:0]    owner_reg;
    logic                as_wr_reg;
    logic [BYTE_W-1:0]   data_reg;

    // channel table memory
    meta_t               meta_mem [CHANNELS];
    meta_t               meta_q_reg;
    logic                meta_q_vld_reg;
    meta_t               meta_cur;
    logic                meta_re, meta_we;
    logic [CH_W-1:0]     meta_raddr, meta_waddr;
    meta_t               meta_wdata;

    // pending result
    status_t             res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                res_sus_v_reg, res_sus_v_next;
    logic [OWNER_W-1:0]  res_sus_id_reg, res_sus_id_next;
    logic                res_wake_v_reg, res_wake_v_next;
    logic [OWNER_W-1:0]  res_wake_id_reg, res_wake_id_next;
    logic                res_rd_ok_reg, res_rd_ok_next;
    logic                res_load;

    // output register
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [BYTE_W-1:0]   m_data_out_reg;
    logic [HANDLE_W-1:0] m_new_handle_reg;
    logic                m_sus_v_reg, m_wake_v_reg;
    logic [OWNER_W-1:0]  m_sus_id_reg, m_wake_id_reg;
    logic                out_load;

    // misc datapath
    logic [CH_W-1:0]     ch_idx;
    logic                found_any;
    logic [CH_W-1:0]     found_idx;
    logic                use_set, use_clr, cnt_inc, cnt_dec;
    logic [CH_W-1:0]     use_idx;
    logic                ram_we, ram_re;
    logic [RAM_W-1:0]    ram_addr;
    logic [BYTE_W-1:0]   ram_rd_data;

    assign ch_idx     = handle_ch(handle_reg);
    assign meta_raddr = handle_ch(s_handle);
    assign meta_cur   = meta_q_vld_reg ? meta_q_reg : META_INIT;

    // lowest free channel
    always_comb begin
        found_any = 1'b0;
        found_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                found_any = 1'b1;
                found_idx = CH_W'(i);
            end
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer and channel update
    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        meta_re          = 1'b0;
        meta_we          = 1'b0;
        meta_waddr       = ch_idx;
        meta_wdata       = meta_cur;
        use_set          = 1'b0;
        use_clr          = 1'b0;
        use_idx          = ch_idx;
        cnt_inc          = 1'b0;
        cnt_dec          = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_addr         = {ch_idx, meta_cur.rptr};
        res_load         = 1'b0;
        res_status_next  = STATUS_OK;
        res_handle_next  = '0;
        res_sus_v_next   = 1'b0;
        res_sus_id_next  = '0;
        res_wake_v_next  = 1'b0;
        res_wake_id_next = '0;
        res_rd_ok_next   = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    meta_re    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_load   = 1'b1;
                state_next = ST_DONE;
                if (act_reg == ACT_OPEN) begin
                    // claim the lowest free channel and reinitialize it
                    if ((open_count_reg < CNT_W'(CHANNELS)) && found_any) begin
                        meta_we    = 1'b1;
                        meta_waddr = found_idx;
                        meta_wdata = META_INIT;
                        if (as_wr_reg) begin
                            meta_wdata.wown = OWNER_W'(owner_reg);
                        end else begin
                            meta_wdata.rown = OWNER_W'(owner_reg);
                        end
                        use_set         = 1'b1;
                        use_idx         = found_idx;
                        cnt_inc         = 1'b1;
                        res_handle_next = HANDLE_W'(found_idx) + HANDLE_BASE;
                    end else begin
                        res_status_next = STATUS_NO_FREE;
                    end
                end else if (handle_bad(handle_reg)) begin
                    res_status_next = STATUS_BAD_HANDLE;
                end else begin
                    unique case (act_reg)
                        ACT_CLOSE: begin
                            // release, keeping the blocked flags
                            if (meta_cur.rown == NO_OWNER && meta_cur.wown == NO_OWNER) begin
                                res_status_next = STATUS_NO_OWNER;
                            end else begin
                                meta_we         = 1'b1;
                                meta_wdata.rptr = '0;
                                meta_wdata.wptr = '0;
                                meta_wdata.occ  = '0;
                                meta_wdata.rown = NO_OWNER;
                                meta_wdata.wown = NO_OWNER;
                                use_clr         = 1'b1;
                                cnt_dec         = (open_count_reg != '0);
                            end
                        end
                        ACT_READ: begin
                            meta_we = 1'b1;
                            if (meta_cur.occ == '0) begin
                                meta_wdata.rblk = 1'b1;
                                res_status_next = STATUS_EMPTY;
                                res_sus_v_next  = 1'b1;
                                res_sus_id_next = meta_cur.rown;
                            end else begin
                                ram_re          = 1'b1;
                                ram_addr        = {ch_idx, meta_cur.rptr};
                                res_rd_ok_next  = 1'b1;
                                meta_wdata.rptr = ptr_inc(meta_cur.rptr);
                                meta_wdata.occ  = meta_cur.occ - 1'b1;
                                if (meta_cur.wblk) begin
                                    meta_wdata.wblk  = 1'b0;
                                    res_wake_v_next  = 1'b1;
                                    res_wake_id_next = meta_cur.wown;
                                end
                            end
                        end
                        ACT_WRITE: begin
                            meta_we = 1'b1;
                            if (meta_cur.occ >= OCC_W'(CHANNEL_DEPTH)) begin
                                meta_wdata.wblk = 1'b1;
                                res_status_next = STATUS_FULL;
                                res_sus_v_next  = 1'b1;
                                res_sus_id_next = meta_cur.wown;
                            end else begin
                                ram_we          = 1'b1;
                                ram_addr        = {ch_idx, meta_cur.wptr};
                                meta_wdata.wptr = ptr_inc(meta_cur.wptr);
                                meta_wdata.occ  = meta_cur.occ + 1'b1;
                                if (meta_cur.rblk) begin
                                    meta_wdata.rblk  = 1'b0;
                                    res_wake_v_next  = 1'b1;
                                    res_wake_id_next = meta_cur.rown;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg    <= action_t'(s_action);
            handle_reg <= s_handle;
            owner_reg  <= s_owner_id;
            as_wr_reg  <= s_open_as_writer;
            data_reg   <= s_data_in;
        end
    end

    // channel table memory, registered read
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re) begin
            meta_q_reg <= meta_mem[meta_raddr];
        end
    end

    // table valid bits, in-use flags and open count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_vld_reg   <= '0;
            meta_q_vld_reg <= 1'b0;
            in_use_reg     <= '0;
            open_count_reg <= '0;
        end else begin
            if (meta_we) begin
                meta_vld_reg[meta_waddr] <= 1'b1;
            end
            if (meta_re) begin
                meta_q_vld_reg <= meta_vld_reg[meta_raddr];
            end
            if (use_set) begin
                in_use_reg[use_idx] <= 1'b1;
            end else if (use_clr) begin
                in_use_reg[use_idx] <= 1'b0;
            end
            if (cnt_inc) begin
                open_count_reg <= open_count_reg + 1'b1;
            end else if (cnt_dec) begin
                open_count_reg <= open_count_reg - 1'b1;
            end
        end
    end

    // ring buffer storage
    mcbp_byte_ram #(
        .ADDR_W (RAM_W)
    ) u_byte_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .rd_en   (ram_re),
        .addr    (ram_addr),
        .wr_data (data_reg),
        .rd_data (ram_rd_data)
    );

    // pending result
    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_status_reg  <= res_status_next;
            res_handle_reg  <= res_handle_next;
            res_sus_v_reg   <= res_sus_v_next;
            res_sus_id_reg  <= res_sus_id_next;
            res_wake_v_reg  <= res_wake_v_next;
            res_wake_id_reg <= res_wake_id_next;
            res_rd_ok_reg   <= res_rd_ok_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg     <= res_status_reg;
            m_data_out_reg   <= res_rd_ok_reg ? ram_rd_data : '0;
            m_new_handle_reg <= res_handle_reg;
            m_sus_v_reg      <= res_sus_v_reg;
            m_sus_id_reg     <= res_sus_id_reg;
            m_wake_v_reg     <= res_wake_v_reg;
            m_wake_id_reg    <= res_wake_id_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_data_out      = m_data_out_reg;
    assign m_new_handle    = m_new_handle_reg;
    assign m_suspend_valid = m_sus_v_reg;
    assign m_suspend_id    = m_sus_id_reg;
    assign m_wake_valid    = m_wake_v_reg;
    assign m_wake_id       = m_wake_id_reg;

`ifndef SYNTHESIS
    // open count tracks the in-use flags
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(in_use_reg) == int'(open_count_reg))
        else $error("open count differs from in-use flags");

    // a result is never loaded over one that waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // suspend only comes with a blocked status
    a_suspend_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_suspend_valid) |->
            (m_status == STATUS_EMPTY || m_status == STATUS_FULL))
        else $error("suspend without blocked status");

    // table read and read-modify-write never overlap
    a_meta_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_we |-> (!meta_re && $past(state_reg) == ST_IDLE))
        else $error("channel table access overlap");
`endif

endmodule

FILE: verif/testbench.sv
// testbench for multi_channel_byte_pipe: directed and random open, close, read and write
// traffic, checked item by item against a behavioral model of the channel table
// depends on mcbp_pkg and the multi_channel_byte_pipe rtl

module testbench;
    import mcbp_pkg::*;

    localparam int CHANNELS            = DEF_CHANNELS;
    localparam int DEPTH               = DEF_CHANNEL_DEPTH;
    localparam int STALL_LIMIT         = 2000;
    localparam int HOLD_OFF_CYCLES     = 150;
    localparam int RANDOM_PER_PHASE    = 60;
    localparam int DRAIN_CYCLES        = 20;

    typedef struct packed {
        status_t              status;
        logic [BYTE_W-1:0]    data_out;
        logic [HANDLE_W-1:0]  new_handle;
        logic                 suspend_valid;
        logic [OWNER_W-1:0]   suspend_id;
        logic                 wake_valid;
        logic [OWNER_W-1:0]   wake_id;
    } pipe_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_action = ACT_OPEN;
    logic [HANDLE_W-1:0]   s_handle = '0;
    logic [PID_W-1:0]      s_owner_id = '0;
    logic                  s_open_as_writer = 1'b0;
    logic [BYTE_W-1:0]     s_data_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_status;
    logic [BYTE_W-1:0]     m_data_out;
    logic [HANDLE_W-1:0]   m_new_handle;
    logic                  m_suspend_valid;
    logic [OWNER_W-1:0]    m_suspend_id;
    logic                  m_wake_valid;
    logic [OWNER_W-1:0]    m_wake_id;

    // channel table model
    logic [BYTE_W-1:0]     ring_mem [CHANNELS][DEPTH];
    int                    rd_ptr [CHANNELS];
    int                    wr_ptr [CHANNELS];
    int                    fill_level [CHANNELS];
    bit                    rd_blocked [CHANNELS];
    bit                    wr_blocked [CHANNELS];
    logic [OWNER_W-1:0]    rd_owner [CHANNELS];
    logic [OWNER_W-1:0]    wr_owner [CHANNELS];
    bit                    in_use [CHANNELS];
    int                    open_total;

    pipe_result_t          expected_results [$];
    pipe_result_t          last_prediction;
    int                    error_count = 0;
    int                    stall_cycles = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_off_left = 0;

    multi_channel_byte_pipe i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_handle         (s_handle),
        .s_owner_id       (s_owner_id),
        .s_open_as_writer (s_open_as_writer),
        .s_data_in        (s_data_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data_out       (m_data_out),
        .m_new_handle     (m_new_handle),
        .m_suspend_valid  (m_suspend_valid),
        .m_suspend_id     (m_suspend_id),
        .m_wake_valid     (m_wake_valid),
        .m_wake_id        (m_wake_id)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_channel_state(int ch);
        rd_ptr[ch]     = 0;
        wr_ptr[ch]     = 0;
        fill_level[ch] = 0;
        rd_owner[ch]   = NO_OWNER;
        wr_owner[ch]   = NO_OWNER;
    endfunction

    // expected result of one item, advancing the table model
    function automatic pipe_result_t predict_pipe_result(action_t act, logic [HANDLE_W-1:0] hnd,
            logic [PID_W-1:0] pid, logic as_writer, logic [BYTE_W-1:0] din);
        pipe_result_t r;
        int ch;
        r = '0;
        r.status = STATUS_OK;
        if (act == ACT_OPEN) begin
            ch = -1;
            if (open_total < CHANNELS) begin
                for (int c = CHANNELS - 1; c >= 0; c--) begin
                    if (!in_use[c]) ch = c;
                end
            end
            if (ch < 0) begin
                r.status = STATUS_NO_FREE;
            end else begin
                clear_channel_state(ch);
                rd_blocked[ch] = 1'b0;
                wr_blocked[ch] = 1'b0;
                if (as_writer) wr_owner[ch] = {1'b0, pid};
                else rd_owner[ch] = {1'b0, pid};
                in_use[ch] = 1'b1;
                open_total++;
                r.new_handle = HANDLE_W'(ch) + HANDLE_BASE;
            end
        end else if (hnd < HANDLE_BASE || hnd > CHANNELS + 2) begin
            r.status = STATUS_BAD_HANDLE;
        end else begin
            ch = hnd - HANDLE_BASE;
            case (act)
                ACT_CLOSE: begin
                    if (rd_owner[ch] == NO_OWNER && wr_owner[ch] == NO_OWNER) begin
                        r.status = STATUS_NO_OWNER;
                    end else begin
                        // blocked flags survive a close
                        clear_channel_state(ch);
                        in_use[ch] = 1'b0;
                        if (open_total > 0) open_total--;
                    end
                end
                ACT_READ: begin
                    if (fill_level[ch] == 0) begin
                        rd_blocked[ch]  = 1'b1;
                        r.status        = STATUS_EMPTY;
                        r.suspend_valid = 1'b1;
                        r.suspend_id    = rd_owner[ch];
                    end else begin
                        r.data_out     = ring_mem[ch][rd_ptr[ch]];
                        rd_ptr[ch]     = (rd_ptr[ch] + 1) % DEPTH;
                        fill_level[ch] = fill_level[ch] - 1;
                        if (wr_blocked[ch]) begin
                            wr_blocked[ch] = 1'b0;
                            r.wake_valid   = 1'b1;
                            r.wake_id      = wr_owner[ch];
                        end
                    end
                end
                default: begin
                    if (fill_level[ch] >= DEPTH) begin
                        wr_blocked[ch]  = 1'b1;
                        r.status        = STATUS_FULL;
                        r.suspend_valid = 1'b1;
                        r.suspend_id    = wr_owner[ch];
                    end else begin
                        ring_mem[ch][wr_ptr[ch]] = din;
                        wr_ptr[ch]     = (wr_ptr[ch] + 1) % DEPTH;
                        fill_level[ch] = fill_level[ch] + 1;
                        if (rd_blocked[ch]) begin
                            rd_blocked[ch] = 1'b0;
                            r.wake_valid   = 1'b1;
                            r.wake_id      = rd_owner[ch];
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("ERROR: %s got %0d expected %0d at %0t", field, got, want, $time);
        error_count++;
    endtask

    // send one item; fields that the action ignores get random values
    task automatic send_item(action_t act, int hnd, int pid, bit as_writer, int din);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= act;
        s_handle         <= (act == ACT_OPEN) ? HANDLE_W'($urandom) : HANDLE_W'(hnd);
        s_owner_id       <= (act == ACT_OPEN) ? PID_W'(pid) : PID_W'($urandom);
        s_open_as_writer <= (act == ACT_OPEN) ? as_writer : 1'($urandom);
        s_data_in        <= (act == ACT_WRITE) ? BYTE_W'(din) : BYTE_W'($urandom);
        do @(posedge aclk); while (!s_ready);
        last_prediction = predict_pipe_result(action_t'(s_action), s_handle, s_owner_id,
                                              s_open_as_writer, s_data_in);
        expected_results.push_back(last_prediction);
        @(negedge aclk);
    endtask

    // sender pauses until every result is back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // extremes, every action and the corner cases on a fresh table
    task automatic test_basic_operations();
        send_idle_pct = 21;
        recv_idle_pct = 47;
        // read of a never opened channel suspends nobody
        send_item(ACT_READ, HANDLE_BASE, 0, 0, 0);
        send_item(ACT_OPEN, 0, 0, 1'b0, 0);
        send_item(ACT_OPEN, 0, 32767, 1'b1, 0);
        send_item(ACT_READ, HANDLE_BASE, 0, 0, 0);
        send_item(ACT_WRITE, HANDLE_BASE, 0, 0, 8'h00);
        send_item(ACT_WRITE, HANDLE_BASE, 0, 0, 8'hFF);
        send_item(ACT_READ, HANDLE_BASE, 0, 0, 0);
        send_item(ACT_READ, HANDLE_BASE, 0, 0, 0);
        // close twice, then a channel never opened
        send_item(ACT_CLOSE, HANDLE_BASE + 1, 0, 0, 0);
        send_item(ACT_CLOSE, HANDLE_BASE + 1, 0, 0, 0);
        send_item(ACT_CLOSE, CHANNELS + 2, 0, 0, 0);
        // handles outside the table
        send_item(ACT_CLOSE, 0, 0, 0, 0);
        send_item(ACT_READ, HANDLE_BASE - 1, 0, 0, 0);
        send_item(ACT_WRITE, CHANNELS + 3, 0, 0, 8'h3C);
        send_item(ACT_CLOSE, 127, 0, 0, 0);
        send_item(ACT_READ, 127, 0, 0, 0);
        // closed channel still moves bytes
        send_item(ACT_WRITE, HANDLE_BASE + 1, 0, 0, 8'hA5);
        send_item(ACT_READ, HANDLE_BASE + 1, 0, 0, 0);
        // blocked reader survives close and is woken with no owner
        send_item(ACT_READ, HANDLE_BASE, 0, 0, 0);
        send_item(ACT_CLOSE, HANDLE_BASE, 0, 0, 0);
        send_item(ACT_WRITE, HANDLE_BASE, 0, 0, 8'h5A);
        send_item(ACT_READ, HANDLE_BASE, 0, 0, 0);
        // reopen takes the lowest free channel and reinitializes it
        send_item(ACT_OPEN, 0, 16'h2AAA, 1'b1, 0);
        send_item(ACT_CLOSE, HANDLE_BASE, 0, 0, 0);
    endtask

    // fill the whole table, refuse further opens, then release everything
    task automatic test_table_full();
        send_idle_pct = 21;
        recv_idle_pct = 47;
        while (open_total < CHANNELS)
            send_item(ACT_OPEN, 0, $urandom_range(32767), 1'($urandom), 0);
        send_item(ACT_OPEN, 0, $urandom_range(32767), 1'b0, 0);
        send_item(ACT_OPEN, 0, $urandom_range(32767), 1'b1, 0);
        send_item(ACT_CLOSE, HANDLE_BASE + 17, 0, 0, 0);
        send_item(ACT_OPEN, 0, $urandom_range(32767), 1'b0, 0);
        send_item(ACT_CLOSE, CHANNELS + 2, 0, 0, 0);
        send_item(ACT_OPEN, 0, $urandom_range(32767), 1'b1, 0);
        for (int c = 0; c < CHANNELS; c++)
            send_item(ACT_CLOSE, c + HANDLE_BASE, 0, 0, 0);
    endtask

    // fill one channel past full under a long receiver hold-off, wrap and drain it
    task automatic test_channel_full_and_backpressure();
        int hnd;
        send_idle_pct = 47;
        recv_idle_pct = 21;
        send_item(ACT_OPEN, 0, $urandom_range(32767), 1'b1, 0);
        hnd = last_prediction.new_handle;
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (DEPTH) send_item(ACT_WRITE, hnd, 0, 0, $urandom_range(255));
        send_item(ACT_WRITE, hnd, 0, 0, $urandom_range(255));
        send_item(ACT_READ, hnd, 0, 0, 0);
        send_item(ACT_WRITE, hnd, 0, 0, $urandom_range(255));
        repeat (DEPTH) send_item(ACT_READ, hnd, 0, 0, 0);
        send_item(ACT_READ, hnd, 0, 0, 0);
        send_item(ACT_CLOSE, hnd, 0, 0, 0);
    endtask

    // mostly bursts on open channels, with opens, closes and stray handles mixed in
    task automatic test_random_traffic();
        int open_list [$];
        int sent;
        int pick;
        int hnd;
        int burst_len;
        int write_bias;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 47 : 0;
            recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 21 : 0;
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                open_list.delete();
                for (int c = 0; c < CHANNELS; c++) begin
                    if (in_use[c]) open_list.push_back(c);
                end
                if (open_list.size() != 0)
                    hnd = open_list[$urandom_range(open_list.size() - 1)] + HANDLE_BASE;
                else
                    hnd = $urandom_range(CHANNELS + 2, HANDLE_BASE);
                pick = $urandom_range(99);
                if (pick < 8 || open_list.size() == 0) begin
                    send_item(ACT_OPEN, 0, $urandom_range(32767), 1'($urandom), 0);
                    sent++;
                end else if (pick < 14) begin
                    send_item(ACT_CLOSE, hnd, 0, 0, 0);
                    sent++;
                end else if (pick < 20) begin
                    send_item(action_t'($urandom_range(3, 1)), $urandom_range(127), 0, 0,
                              $urandom_range(255));
                    sent++;
                end else begin
                    burst_len  = $urandom_range(12, 1);
                    write_bias = $urandom_range(80, 20);
                    repeat (burst_len) begin
                        if ($urandom_range(99) < write_bias)
                            send_item(ACT_WRITE, hnd, 0, 0, $urandom_range(255));
                        else
                            send_item(ACT_READ, hnd, 0, 0, 0);
                        sent++;
                    end
                end
            end
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        pipe_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, status", m_status, -1);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_status !== exp_r.status)
                    report_mismatch("status", m_status, exp_r.status);
                if (m_data_out !== exp_r.data_out)
                    report_mismatch("data_out", m_data_out, exp_r.data_out);
                if (m_new_handle !== exp_r.new_handle)
                    report_mismatch("new_handle", m_new_handle, exp_r.new_handle);
                if (m_suspend_valid !== exp_r.suspend_valid)
                    report_mismatch("suspend_valid", m_suspend_valid, exp_r.suspend_valid);
                if (m_suspend_id !== exp_r.suspend_id)
                    report_mismatch("suspend_id", m_suspend_id, exp_r.suspend_id);
                if (m_wake_valid !== exp_r.wake_valid)
                    report_mismatch("wake_valid", m_wake_valid, exp_r.wake_valid);
                if (m_wake_id !== exp_r.wake_id)
                    report_mismatch("wake_id", m_wake_id, exp_r.wake_id);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT - 1) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            clear_channel_state(c);
            rd_blocked[c] = 1'b0;
            wr_blocked[c] = 1'b0;
            in_use[c]     = 1'b0;
        end
        open_total = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_operations();
        wait_results_drained();
        test_table_full();
        wait_results_drained();
        test_channel_full_and_backpressure();
        wait_results_drained();
        test_random_traffic();
        wait_results_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mcbp_pkg.sv
design/mcbp_byte_ram.sv
design/multi_channel_byte_pipe.sv
verif/testbench.sv
